// ----- design/rrqs_pkg.sv -----
package rrqs_pkg;

  localparam int QueueDepth = 64;
  localparam int CountW     = $clog2(QueueDepth + 1);

  localparam int IdW        = 8;
  localparam int KindW      = 3;
  localparam int QuantW     = 8;

  // event kinds
  localparam logic [KindW-1:0] KIND_MOVED    = 3'd0;
  localparam logic [KindW-1:0] KIND_FINISHED = 3'd1;
  localparam logic [KindW-1:0] KIND_BLOCKED  = 3'd2;
  localparam logic [KindW-1:0] KIND_NEW      = 3'd3;
  localparam logic [KindW-1:0] KIND_READY    = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_EMPTY_BLK = 2'd3;

  localparam logic [QuantW-1:0] QUANTUM_RESET = 8'd3;

  // controls broadcast to every cell of the queue
  typedef struct packed {
    logic           cmp_en;     // latch id compare for a new event
    logic [IdW-1:0] cmp_id;
    logic           load;       // commit the next queue contents
    logic           rm_finish;  // remove first matching id
    logic           rm_head;    // remove head (block on nonempty queue)
    logic [IdW-1:0] app_id;     // appended id
    logic           rot;        // rotate head to tail after the update
    logic [IdW-1:0] head1;      // head after the update, before rotation
  } cell_ctrl_t;

endpackage

// ----- design/rrqs_cell.sv -----
module rrqs_cell
  import rrqs_pkg::*;
(
  input  logic           clk,
  input  cell_ctrl_t     ctrl,
  input  logic           occ,        // cell holds a live entry
  input  logic           app_here,   // append lands in this cell
  input  logic           tail_here,  // rotated head lands in this cell
  input  logic           hit_in,     // match seen in a cell closer to the head
  input  logic [IdW-1:0] q_right,
  input  logic [IdW-1:0] q1_right,
  output logic           hit_out,
  output logic [IdW-1:0] q,
  output logic [IdW-1:0] q1,
  output logic [IdW-1:0] q2
);

  logic [IdW-1:0] q_r;
  logic           match_r;
  logic           shift;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      match_r <= occ && (q_r == ctrl.cmp_id);
    end
    if (ctrl.load) begin
      q_r <= q2;
    end
  end

  assign hit_out = hit_in | match_r;
  // everything at or behind the removed entry moves one step toward the head
  assign shift   = ctrl.rm_head | (ctrl.rm_finish & hit_out);

  always_comb begin
    if (shift) begin
      q1 = q_right;
    end else if (app_here) begin
      q1 = ctrl.app_id;
    end else begin
      q1 = q_r;
    end
    if (ctrl.rot) begin
      q2 = tail_here ? ctrl.head1 : q1_right;
    end else begin
      q2 = q1;
    end
  end

  assign q = q_r;

endmodule

// ----- design/round_robin_quantum_scheduler_top.sv -----
// Round-robin scheduler with a quantum. The ready queue is a row of
// QueueDepth cells that shift toward the head; a finish removes the first
// matching id, a block removes the head, new/ready appends at the tail, and
// a pending grant rotates the head to the tail once the move count reaches
// the quantum. Each event is first taken, its id compared in every cell,
// then the cell row updated and shifted and the result register loaded.
// The next event is taken once the result is loaded; a result waiting on
// out_stall holds off the update of the next. The user is to write the
// quantum register through cfg_* between events; it is not enforced.
module round_robin_quantum_scheduler_top
  import rrqs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KindW-1:0]  in_kind,
  input  logic [IdW-1:0]    in_client_id,
  input  logic [IdW-1:0]    in_resource_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_grant_valid,
  output logic [IdW-1:0]    out_grant_id,
  output logic              out_blocked_valid,
  output logic [IdW-1:0]    out_blocked_id,
  output logic [IdW-1:0]    out_blocked_resource,
  output logic [1:0]        out_status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [QuantW-1:0] cfg_quantum
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [KindW-1:0]   kind_r;
  logic [IdW-1:0]     cid_r, rid_r;
  logic [QuantW-1:0]  quantum_r;
  logic [CountW-1:0]  count_r, count_nxt;
  logic [QuantW-1:0]  qcnt_r, qcnt_nxt;
  logic               pend_r, pend_nxt;

  logic               out_valid_r;
  logic               o_gv_r, o_bv_r;
  logic [IdW-1:0]     o_gid_r, o_bid_r, o_bres_r;
  logic [1:0]         o_stat_r;

  logic               accept, exec, out_free;
  cell_ctrl_t         ctrl;
  logic [QueueDepth-1:0] occ, app_hot, tail_hot;
  logic [QueueDepth:0]   hit;
  logic [IdW-1:0]     q   [QueueDepth+1];
  logic [IdW-1:0]     q1  [QueueDepth+1];
  logic [IdW-1:0]     q2  [QueueDepth];

  logic               is_app, app_ok, found, rm, grant, rot;
  logic [CountW-1:0]  c1;
  logic [QuantW-1:0]  qc1;
  logic               pend1;
  logic [1:0]         stat;
  logic               bv;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign exec     = (state_r == S_EXEC) && out_free;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // event decode and count update
  always_comb begin
    is_app = (kind_r == KIND_NEW) || (kind_r == KIND_READY);
    app_ok = is_app && (count_r < CountW'(QueueDepth));
    found  = hit[QueueDepth];
    bv     = (kind_r == KIND_BLOCKED) && (count_r != '0);
    rm     = ((kind_r == KIND_FINISHED) && found) || bv;
    c1     = count_r - CountW'(rm) + CountW'(app_ok);
    qc1    = qcnt_r;
    if (kind_r == KIND_MOVED && qcnt_r != '1) begin
      qc1 = qcnt_r + 1'b1;
    end
    pend1 = pend_r || (kind_r <= KIND_READY);
    grant = pend1 && (c1 != '0);
    rot   = grant && (qc1 >= quantum_r);
    case (kind_r) inside
      KIND_FINISHED: stat = found ? STAT_OK : STAT_NOT_FOUND;
      KIND_BLOCKED:  stat = bv ? STAT_OK : STAT_EMPTY_BLK;
      KIND_NEW, KIND_READY: stat = app_ok ? STAT_OK : STAT_FULL;
      default:       stat = STAT_OK;
    endcase
    count_nxt = exec ? c1 : count_r;
    qcnt_nxt  = exec ? (rot ? '0 : qc1) : qcnt_r;
    pend_nxt  = exec ? (pend1 && !grant) : pend_r;
  end

  always_comb begin
    for (int k = 0; k < QueueDepth; k++) begin
      occ[k]      = (CountW'(k) < count_r);
      app_hot[k]  = app_ok && (CountW'(k) == count_r);
      tail_hot[k] = (CountW'(k) == c1 - 1'b1);
    end
  end

  always_comb begin
    ctrl.cmp_en    = accept;
    ctrl.cmp_id    = in_client_id;
    ctrl.load      = exec;
    ctrl.rm_finish = (kind_r == KIND_FINISHED);
    ctrl.rm_head   = bv;
    ctrl.app_id    = cid_r;
    ctrl.rot       = rot;
    ctrl.head1     = q1[0];
  end

  assign hit[0]          = 1'b0;
  assign q[QueueDepth]   = '0;
  assign q1[QueueDepth]  = '0;

  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    rrqs_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ[g]),
      .app_here  (app_hot[g]),
      .tail_here (tail_hot[g]),
      .hit_in    (hit[g]),
      .q_right   (q[g+1]),
      .q1_right  (q1[g+1]),
      .hit_out   (hit[g+1]),
      .q         (q[g]),
      .q1        (q1[g]),
      .q2        (q2[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      quantum_r   <= QUANTUM_RESET;
      count_r     <= '0;
      qcnt_r      <= '0;
      pend_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      qcnt_r  <= qcnt_nxt;
      pend_r  <= pend_nxt;
      if (cfg_valid && cfg_ready) begin
        quantum_r <= cfg_quantum;
      end
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      cid_r  <= in_client_id;
      rid_r  <= in_resource_id;
    end
    if (exec) begin
      o_gv_r   <= grant;
      o_gid_r  <= grant ? q2[0] : '0;
      o_bv_r   <= bv;
      o_bid_r  <= bv ? q[0] : '0;
      o_bres_r <= bv ? rid_r : '0;
      o_stat_r <= stat;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_grant_valid      = o_gv_r;
  assign out_grant_id         = o_gid_r;
  assign out_blocked_valid    = o_bv_r;
  assign out_blocked_id       = o_bid_r;
  assign out_blocked_resource = o_bres_r;
  assign out_status           = o_stat_r;

endmodule
